/* sv/uctq_pkg.sv */
// Shared types and constants for the UART transmit queue with CTS handshake.
package uctq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int FUNC_W      = 2;
    localparam int ID_W        = 8;
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int ENTRY_W     = ID_W + BYTE_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUT    = 2'd0,
        FN_TXDONE = 2'd1,
        FN_CTS    = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TX    = 2'd0,
        KIND_REPLY = 2'd1,
        KIND_DROP  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_WAIT_TXDONE = 2'd1,
        PH_WAIT_LOW    = 2'd2,
        PH_WAIT_HIGH   = 2'd3
    } phase_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctl_state_t;

endpackage

/* sv/uctq_if.sv */
// Valid/ready channel interfaces for requests in and results out.
interface uctq_in_if
    import uctq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   requester_id;
    logic [BYTE_W-1:0] data_byte;
    logic              cts_level;

    modport source (output valid, func, requester_id, data_byte, cts_level, input ready);
    modport sink   (input valid, func, requester_id, data_byte, cts_level, output ready);
endinterface

interface uctq_out_if
    import uctq_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] tx_byte;
    logic [ID_W-1:0]   reply_id;

    modport source (output valid, kind, tx_byte, reply_id, input ready);
    modport sink   (input valid, kind, tx_byte, reply_id, output ready);
endinterface

/* sv/uctq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uctq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/uart_tx_cts_handshake_queue_core.sv */
// Top level: request FIFO in RAM, transmit sequencing and CTS handshake.
// A request is captured at acceptance and evaluated in the evaluate state, which waits
//   while the output register is full and not drained; only then is a new one taken.
//   The head entry comes from the single RAM read port, registered at acceptance.
// Reset: clears indexes, count, phase and handshake state; the FIFO RAM is not
//   cleared, entries are only read between head and tail, so no clearing pass.
module uart_tx_cts_handshake_queue_core
    import uctq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    uctq_in_if.sink           req,
    uctq_out_if.source        rsp
);

    // Control state and the request captured at acceptance.
    ctl_state_t        state_reg, state_next;
    logic [FUNC_W-1:0] func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              level_reg;

    // Queue bookkeeping; the entries themselves live in RAM.
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    phase_t            phase_reg, phase_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic [ID_W-1:0]   reply_id_reg;

    logic              in_ready;
    logic              exec_go;
    logic              accept;

    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] head_entry;
    logic               have_entry;
    logic               head_valid_pre;
    logic               head_valid_post;
    logic               is_put;
    logic               full;
    logic               put_ok;
    logic               drop;
    logic               finished;
    logic               start;
    logic               res_valid;
    logic [CNT_W-1:0]   count_put;
    phase_t             phase_ev;
    logic [KIND_W-1:0]  res_kind;
    logic [BYTE_W-1:0]  res_byte;
    logic [ID_W-1:0]    res_id;

    assign accept = req.valid && in_ready;

    // The RAM always reads at the head; the head only moves at commit, which
    // never coincides with acceptance, so the data is fresh in the evaluate cycle.
    uctq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (exec_go && put_ok),
        .wr_addr (tail_reg),
        .wr_data ({id_reg, data_reg}),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer: outputs. Hold the evaluate cycle while the output register is
    // still full and not being drained.
    always_comb
    begin
        in_ready = 1'b0;
        exec_go  = 1'b0;
        unique case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_EXEC: exec_go  = !out_valid_reg || rsp.ready;
            default:
            begin
                in_ready = 1'b0;
                exec_go  = 1'b0;
            end
        endcase
    end

    // Evaluate one request: apply the event or the put, then start an idle valid head,
    // then answer and pop a finished handshake.
    always_comb
    begin
        have_entry     = count_reg != '0;
        head_valid_pre = have_entry && (rd_data[ENTRY_W-1:BYTE_W] != '0);

        phase_ev = phase_reg;
        finished = 1'b0;
        if (func_reg == FN_CTS && head_valid_pre)
        begin
            if (level_reg && phase_reg == PH_WAIT_HIGH)
            begin
                finished = 1'b1;
            end
            else if (!level_reg && phase_reg == PH_WAIT_LOW)
            begin
                phase_ev = PH_WAIT_HIGH;
            end
        end
        if (func_reg == FN_TXDONE && head_valid_pre && phase_reg == PH_WAIT_TXDONE)
        begin
            phase_ev = PH_WAIT_LOW;
        end

        is_put    = func_reg == FN_PUT;
        full      = count_reg == CNT_W'(QUEUE_DEPTH);
        put_ok    = is_put && !full;
        drop      = is_put && full;
        count_put = count_reg + CNT_W'(put_ok);

        // On an empty queue the new put becomes the head: forward it.
        head_entry      = have_entry ? rd_data : {id_reg, data_reg};
        head_valid_post = (count_put != '0) && (head_entry[ENTRY_W-1:BYTE_W] != '0);
        start           = head_valid_post && phase_ev == PH_IDLE;

        if (start)
        begin
            phase_next = PH_WAIT_TXDONE;
        end
        else if (finished)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            phase_next = phase_ev;
        end

        count_next = count_put - CNT_W'(finished);

        if (put_ok)
        begin
            tail_next = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        else
        begin
            tail_next = tail_reg;
        end
        if (finished)
        begin
            head_next = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        else
        begin
            head_next = head_reg;
        end

        // One result at most: a drop wins, then a start, then a reply.
        res_valid = drop || start || finished;
        res_kind  = KIND_REPLY;
        res_byte  = '0;
        res_id    = head_entry[ENTRY_W-1:BYTE_W];
        if (drop)
        begin
            res_kind = KIND_DROP;
            res_id   = id_reg;
        end
        else if (start)
        begin
            res_kind = KIND_TX;
            res_byte = head_entry[BYTE_W-1:0];
            res_id   = '0;
        end
    end

    always_comb
    begin
        if (exec_go && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec_go)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                phase_reg <= phase_next;
            end
        end
    end

    // Payload registers: capture the request, load the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= req.func;
            id_reg    <= req.requester_id;
            data_reg  <= req.data_byte;
            level_reg <= req.cts_level;
        end
        if (exec_go && res_valid)
        begin
            kind_reg     <= res_kind;
            tx_byte_reg  <= res_byte;
            reply_id_reg <= res_id;
        end
    end

    assign req.ready    = in_ready;
    assign rsp.valid    = out_valid_reg;
    assign rsp.kind     = kind_reg;
    assign rsp.tx_byte  = tx_byte_reg;
    assign rsp.reply_id = reply_id_reg;

    // Checks on queue bookkeeping and the stall path.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_busy_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> count_reg != '0)
        else $error("handshake in progress on an empty queue");

    a_index_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with entry count");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && out_valid_reg && !rsp.ready) |=>
            (state_reg == S_EXEC && $stable(count_reg) && $stable(phase_reg)))
        else $error("request evaluated while output register blocked");

endmodule

/* tb/sv/tb_uart_tx_cts_handshake_queue_core.sv */
// Self-checking testbench for the UART transmit queue with CTS handshake.
module tb_uart_tx_cts_handshake_queue_core
    import uctq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int PHASE_ITEMS    = 280;
    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;

    // One request on the input channel.
    typedef struct packed {
        func_t             func;
        logic [ID_W-1:0]   id;
        logic [BYTE_W-1:0] data;
        logic              lvl;
    } txq_req_t;

    // One result on the output channel.
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] tx_byte;
        logic [ID_W-1:0]   reply_id;
    } txq_res_t;

    // Directed row: the request, and where it is obvious, the result typed in.
    // Rows with typed low are checked against the predictor instead.
    typedef struct packed {
        func_t             func;
        logic [ID_W-1:0]   id;
        logic [BYTE_W-1:0] data;
        logic              lvl;
        logic              typed;
        logic              has_res;
        kind_t             kind;
        logic [BYTE_W-1:0] txb;
        logic [ID_W-1:0]   rid;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // empty queue: every event is ignored, unused func does nothing
        '{FN_TXDONE, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b0, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b1, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_NONE,   8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        // first put starts at once
        '{FN_PUT,    8'hFF, 8'h00, 1'b0, 1'b1, 1'b1, KIND_TX,    8'h00, 8'h00},
        // CTS changes while waiting for transmit complete: ignored
        '{FN_CTS,    8'h00, 8'h00, 1'b1, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b0, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        // second put queues behind the busy head
        '{FN_PUT,    8'h01, 8'hFF, 1'b1, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_TXDONE, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        // repeated transmit complete and CTS high while waiting for low: ignored
        '{FN_TXDONE, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b1, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b0, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b0, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00},
        // CTS high completes the handshake and answers the head
        '{FN_CTS,    8'h00, 8'h00, 1'b1, 1'b1, 1'b1, KIND_REPLY, 8'h00, 8'hFF},
        // next byte starts on the following item, even an unused func
        '{FN_NONE,   8'h00, 8'h00, 1'b0, 1'b1, 1'b1, KIND_TX,    8'hFF, 8'h00},
        '{FN_TXDONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b1, 1'b1, 1'b1, KIND_REPLY, 8'h00, 8'h01},
        '{FN_PUT,    8'h80, 8'h55, 1'b0, 1'b1, 1'b1, KIND_TX,    8'h55, 8'h00},
        '{FN_PUT,    8'h7F, 8'hAA, 1'b1, 1'b0, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_TXDONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b1, 1'b1, 1'b1, KIND_REPLY, 8'h00, 8'h80},
        // transmit complete right after an answer: event ignored, next byte starts
        '{FN_TXDONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_TX,    8'h00, 8'h00},
        '{FN_CTS,    8'h00, 8'h00, 1'b0, 1'b1, 1'b0, KIND_TX,    8'h00, 8'h00}
    };

    logic clk = 1'b0;
    logic rst_n;

    uctq_in_if  req_ch ();
    uctq_out_if rsp_ch ();

    uart_tx_cts_handshake_queue_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: pending put requests, indexes and handshake phase.
    logic [ENTRY_W-1:0] pend_mem [QUEUE_DEPTH];
    int                 pend_head;
    int                 pend_tail;
    int                 pend_count;
    phase_t             link_phase;

    txq_res_t txq_outcomes [$];   // results still owed by the block, oldest first
    int       mismatch_count;

    int       src_idle_pct;
    int       snk_idle_pct;
    logic [7:0] hold_req;         // bump to ask the receiver for a long hold-off
    logic [7:0] hold_ack;
    int         hold_left;
    int         quiet_cycles;

    // A head entry is usable only if it is there and its requester id is nonzero.
    function automatic bit head_usable();
        return pend_count != 0 && pend_mem[pend_head][ENTRY_W-1:BYTE_W] != '0;
    endfunction

    // Apply one accepted request to the predictor; return 1 with the result if one is due.
    // Order inside one request: apply the event, start an idle head, answer a
    // finished handshake. Only the first result of the three survives.
    function automatic bit txq_apply_request(input txq_req_t rq, output txq_res_t res);
        bit hs_done;
        bit got;
        hs_done = 1'b0;
        got     = 1'b0;
        res     = '0;
        if (rq.func == FN_CTS && head_usable())
        begin
            if (rq.lvl && link_phase == PH_WAIT_HIGH)
                hs_done = 1'b1;
            else if (!rq.lvl && link_phase == PH_WAIT_LOW)
                link_phase = PH_WAIT_HIGH;
        end
        if (rq.func == FN_TXDONE && head_usable() && link_phase == PH_WAIT_TXDONE)
            link_phase = PH_WAIT_LOW;
        if (rq.func == FN_PUT)
        begin
            if (pend_count >= QUEUE_DEPTH)
            begin
                res = '{KIND_DROP, 8'h00, rq.id};
                got = 1'b1;
            end
            else
            begin
                pend_mem[pend_tail] = {rq.id, rq.data};
                pend_tail           = (pend_tail + 1) % QUEUE_DEPTH;
                pend_count++;
            end
        end
        if (head_usable() && link_phase == PH_IDLE)
        begin
            link_phase = PH_WAIT_TXDONE;
            if (!got)
            begin
                res = '{KIND_TX, pend_mem[pend_head][BYTE_W-1:0], 8'h00};
                got = 1'b1;
            end
        end
        if (hs_done && pend_count > 0)
        begin
            if (!got)
            begin
                res = '{KIND_REPLY, 8'h00, pend_mem[pend_head][ENTRY_W-1:BYTE_W]};
                got = 1'b1;
            end
            pend_head  = (pend_head + 1) % QUEUE_DEPTH;
            pend_count--;
            link_phase = PH_IDLE;
        end
        return got;
    endfunction

    // Pick the request that moves the handshake on from the predicted phase.
    function automatic txq_req_t next_handshake_step();
        txq_req_t rq;
        rq.id   = ID_W'($urandom_range(255, 1));
        rq.data = BYTE_W'($urandom_range(255));
        rq.lvl  = 1'($urandom_range(1));
        case (link_phase)
            PH_WAIT_TXDONE: rq.func = FN_TXDONE;
            PH_WAIT_LOW:
            begin
                rq.func = FN_CTS;
                rq.lvl  = 1'b0;
            end
            PH_WAIT_HIGH:
            begin
                rq.func = FN_CTS;
                rq.lvl  = 1'b1;
            end
            // idle with a queued head: any request starts it
            default:        rq.func = (pend_count == 0) ? FN_PUT : func_t'($urandom_range(3));
        endcase
        return rq;
    endfunction

    // Mostly well-formed handshakes, some extra puts, the rest noise in any phase.
    function automatic txq_req_t random_request();
        txq_req_t rq;
        int       roll;
        roll = $urandom_range(99);
        rq   = next_handshake_step();
        if (roll < 12)
        begin
            rq.func = FN_PUT;
        end
        else if (roll < 30)
        begin
            rq.func = func_t'($urandom_range(3));
            rq.lvl  = 1'($urandom_range(1));
        end
        return rq;
    endfunction

    // Offer one request, with random idle cycles first; return at the accepting edge.
    task automatic send_request(input txq_req_t rq);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= rq.func;
        req_ch.requester_id <= rq.id;
        req_ch.data_byte    <= rq.data;
        req_ch.cts_level    <= rq.lvl;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Send a request and queue whatever result the predictor owes for it.
    task automatic issue_request(input txq_req_t rq);
        txq_res_t res;
        send_request(rq);
        if (txq_apply_request(rq, res))
            txq_outcomes.push_back(res);
    endtask

    // Receiver: check each accepted result against the oldest one owed, then
    // pick ready for the next cycle. A hold-off request drops ready for a long
    // stretch, counted here, so the queue fills and the input stalls.
    always @(posedge clk)
    begin : rx_side
        txq_res_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (txq_outcomes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: MISCOMPARE unexpected result kind=%0d byte=%02h id=%02h",
                         $time, rsp_ch.kind, rsp_ch.tx_byte, rsp_ch.reply_id);
            end
            else
            begin
                want = txq_outcomes.pop_front();
                if (rsp_ch.kind !== want.kind || rsp_ch.tx_byte !== want.tx_byte ||
                    rsp_ch.reply_id !== want.reply_id)
                begin
                    mismatch_count++;
                    $display("%0t: MISCOMPARE expected kind=%0d byte=%02h id=%02h",
                             $time, want.kind, want.tx_byte, want.reply_id);
                    $display("%0t:            actual   kind=%0d byte=%02h id=%02h",
                             $time, rsp_ch.kind, rsp_ch.tx_byte, rsp_ch.reply_id);
                end
            end
        end
        if (hold_req != hold_ack)
        begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog: end the run if no request and no result moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("uart_tx_cts_handshake_queue_core: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        txq_req_t rq;
        txq_res_t res;
        bit       got;

        // Hold every input at a known value through reset.
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.func         = FN_NONE;
        req_ch.requester_id = '0;
        req_ch.data_byte    = '0;
        req_ch.cts_level    = 1'b0;
        rsp_ch.ready        = 1'b0;
        pend_head           = 0;
        pend_tail           = 0;
        pend_count          = 0;
        link_phase          = PH_IDLE;
        mismatch_count      = 0;
        quiet_cycles        = 0;
        hold_req            = '0;
        hold_ack            = '0;
        hold_left           = 0;
        src_idle_pct        = 21;
        snk_idle_pct        = 72;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: field extremes, every func, wrong-phase events.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            rq  = '{DIR_TAB[i].func, DIR_TAB[i].id, DIR_TAB[i].data, DIR_TAB[i].lvl};
            send_request(rq);
            got = txq_apply_request(rq, res);
            if (DIR_TAB[i].typed)
            begin
                if (DIR_TAB[i].has_res)
                    txq_outcomes.push_back('{DIR_TAB[i].kind, DIR_TAB[i].txb, DIR_TAB[i].rid});
            end
            else if (got)
            begin
                txq_outcomes.push_back(res);
            end
        end

        // Random part in three idle settings: sender light / receiver heavy,
        // then swapped, then no idling at all.
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct  = (ph == 0) ? 21 : (ph == 1) ? 72 : 0;
            snk_idle_pct <= (ph == 0) ? 72 : (ph == 1) ? 21 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue_request(random_request());
        end

        // Drain the queue, then block it with an invalid head: events are
        // ignored from then on, and further puts fill it up and get dropped.
        while (pend_count != 0)
            issue_request(next_handshake_step());
        rq    = random_request();
        rq.func = FN_PUT;
        rq.id   = '0;
        issue_request(rq);
        for (int k = 0; k < 8; k++)
        begin
            rq      = random_request();
            rq.func = func_t'($urandom_range(3, 1));
            issue_request(rq);
        end
        // Hold the receiver off while the puts pile up: the queue fills, the
        // drops back up behind the output register and the input stalls.
        hold_req <= hold_req + 8'd1;
        for (int k = 0; k < QUEUE_DEPTH + 2; k++)
        begin
            rq      = random_request();
            rq.func = FN_PUT;
            rq.id   = ID_W'($urandom_range(255));
            issue_request(rq);
        end
        req_ch.valid <= 1'b0;

        // Wait for every owed result, then let the pipeline settle.
        while (txq_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("uart_tx_cts_handshake_queue_core: match");
        else
            $display("uart_tx_cts_handshake_queue_core: mismatch");
        $finish;
    end

endmodule

/* sim.f */
sv/uctq_pkg.sv
sv/uctq_if.sv
sv/uctq_ram.sv
sv/uart_tx_cts_handshake_queue_core.sv
tb/sv/tb_uart_tx_cts_handshake_queue_core.sv
